// ----- rtl/jacobi_3d_seven_point_stencil_defines.svh -----
`ifndef JACOBI_3D_SEVEN_POINT_STENCIL_DEFINES_SVH
`define JACOBI_3D_SEVEN_POINT_STENCIL_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define J3D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define J3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/j3d_pkg.sv -----
`default_nettype none
package j3d_pkg;

  localparam int MaxSideDef = 64;
  localparam int ValueBits  = 32;
  localparam int SizeBits   = 7;
  localparam int MaskBits   = 6;
  localparam int SumBits    = ValueBits + 3;
  localparam int RecipBits  = 27;
  localparam int RecipShift = 28;
  localparam logic signed [RecipBits-1:0] Recip7 = 27'sd38347922;

  typedef enum logic [1:0] {
    CFG_SIZE_X    = 2'd0,
    CFG_SIZE_Y    = 2'd1,
    CFG_SIZE_Z    = 2'd2,
    CFG_FACE_MASK = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SizeBits-1:0] size_x;
    logic [SizeBits-1:0] size_y;
    logic [SizeBits-1:0] size_z;
    logic [MaskBits-1:0] face_mask;
  } cfg_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] cell_value;
    logic                        block_start;
  } cell_in_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] new_value;
    logic [ValueBits-2:0]        max_change;
    logic                        last_cell;
  } cell_out_t;

  // One finished interior cell travelling from the front to the back.
  typedef struct packed {
    logic signed [SumBits-1:0]   sum;
    logic signed [ValueBits-1:0] old;
    logic                        fixed;
    logic                        last;
    logic                        clr;
  } work_t;

endpackage
`default_nettype wire

// ----- rtl/jacobi_3d_seven_point_stencil.sv -----
// A cell passes the front stage, queue, product, value and output registers; one cell per
// cycle unless stalled, as six plane-store copies read centre and five neighbours at once.
// The output register stalls the back pipeline; the front keeps going until the queue fills.
// Reset clears positions, running maximum, handshakes and the registers (8, 8, 8, mask 0).
// The plane store is not cleared and needs no clearing pass.
`default_nettype none
module jacobi_3d_seven_point_stencil
  import j3d_pkg::*;
#(
  parameter int MaxSide = MaxSideDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [SizeBits-1:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire cell_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output cell_out_t        out_data_o
);

  cfg_t  cfg_q;
  work_t push_entry, pop_entry;
  logic  push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x    <= SizeBits'(8);
      cfg_q.size_y    <= SizeBits'(8);
      cfg_q.size_z    <= SizeBits'(8);
      cfg_q.face_mask <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SIZE_X:    cfg_q.size_x    <= cfg_data_i;
        CFG_SIZE_Y:    cfg_q.size_y    <= cfg_data_i;
        CFG_SIZE_Z:    cfg_q.size_z    <= cfg_data_i;
        CFG_FACE_MASK: cfg_q.face_mask <= cfg_data_i[MaskBits-1:0];
        default: begin
        end
      endcase
    end
  end

  j3d_front #(.MaxSide(MaxSide)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .full_i     (full)
  );

  j3d_queue #(.Depth(4)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  j3d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- rtl/j3d_ram.sv -----
`default_nettype none
module j3d_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read-first: a read and a write at one address return the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/j3d_queue.sv -----
`default_nettype none
module j3d_queue
  import j3d_pkg::*;
#(
  parameter int Depth = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire work_t entry_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output work_t      entry_o,
  output logic       empty_o
);

  localparam int PtrW = $clog2(Depth);

  work_t           buf_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/j3d_front.sv -----
`default_nettype none
module j3d_front
  import j3d_pkg::*;
#(
  parameter int MaxSide = MaxSideDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire cell_in_t in_data_i,
  output logic          push_o,
  output work_t         entry_o,
  input  wire logic     full_i
);

  localparam int Pad   = MaxSide + 2;
  localparam int Plane = Pad * Pad;
  localparam int Depth = 2 * Plane;
  localparam int PW    = $clog2(Pad);
  localparam int AW    = $clog2(Depth);

  function automatic logic [PW-1:0] clamp(input logic [SizeBits-1:0] s);
    logic [PW-1:0] r;
    if (s == '0) begin
      r = PW'(1);
    end else if (32'(s) > MaxSide) begin
      r = PW'(MaxSide);
    end else begin
      r = PW'(s);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] addr(input logic slot, input logic [PW-1:0] y,
                                         input logic [PW-1:0] z);
    return (slot ? AW'(Plane) : '0) + AW'(32'(y) * Pad) + AW'(z);
  endfunction

  logic [PW-1:0] sx, sy, sz, x, y, z, i;
  logic [PW-1:0] px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic          accept, interior, fixed, last, leave;
  logic [AW-1:0] raddr [6];
  logic [ValueBits-1:0] rdata [6];

  logic                        s1_valid_q, s1_res_q, s1_fixed_q, s1_last_q, s1_clr_q;
  logic signed [ValueBits-1:0] s1_v_q;
  logic                        pend_q;

  assign sx = clamp(cfg_i.size_x);
  assign sy = clamp(cfg_i.size_y);
  assign sz = clamp(cfg_i.size_z);

  always_comb begin
    if (in_data_i.block_start) begin
      x = '0;
      y = '0;
      z = '0;
    end else begin
      x = ({1'b0, px_q} > {1'b0, sx} + 1'b1) ? '0 : px_q;
      y = ({1'b0, py_q} > {1'b0, sy} + 1'b1) ? '0 : py_q;
      z = ({1'b0, pz_q} > {1'b0, sz} + 1'b1) ? '0 : pz_q;
    end
  end

  assign i        = x - 1'b1;
  assign interior = (x >= PW'(2)) && (y != '0) && (y <= sy) && (z != '0) && (z <= sz);
  assign fixed    = (cfg_i.face_mask[0] && i == PW'(1)) || (cfg_i.face_mask[1] && i == sx) ||
                    (cfg_i.face_mask[2] && y == PW'(1)) || (cfg_i.face_mask[3] && y == sy) ||
                    (cfg_i.face_mask[4] && z == PW'(1)) || (cfg_i.face_mask[5] && z == sz);
  assign last     = (i == sx) && (y == sy) && (z == sz);

  always_comb begin
    px_d = x;
    py_d = y;
    pz_d = z;
    if (z <= sz) begin
      pz_d = z + 1'b1;
    end else begin
      pz_d = '0;
      if (y <= sy) begin
        py_d = y + 1'b1;
      end else begin
        py_d = '0;
        px_d = (x <= sx) ? x + 1'b1 : '0;
      end
    end
  end

  // The centre cell and each stored neighbour come from their own copy of the plane store.
  assign raddr[0] = addr(i[0], y, z);
  assign raddr[1] = addr(x[0], y, z);
  assign raddr[2] = addr(i[0], y - 1'b1, z);
  assign raddr[3] = addr(i[0], y + 1'b1, z);
  assign raddr[4] = addr(i[0], y, z - 1'b1);
  assign raddr[5] = addr(i[0], y, z + 1'b1);

  for (genvar k = 0; k < 6; k++) begin : g_bank
    j3d_ram #(.Width(ValueBits), .Depth(Depth)) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept),
      .waddr_i (addr(x[0], y, z)),
      .wdata_i (in_data_i.cell_value),
      .re_i    (accept && interior),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
  end

  assign push_o     = s1_valid_q && s1_res_q && !full_i;
  assign leave      = !s1_res_q || !full_i;
  assign in_ready_o = !s1_valid_q || leave;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    entry_o.sum = SumBits'(s1_v_q) + SumBits'($signed(rdata[0])) +
                  SumBits'($signed(rdata[1])) + SumBits'($signed(rdata[2])) +
                  SumBits'($signed(rdata[3])) + SumBits'($signed(rdata[4])) +
                  SumBits'($signed(rdata[5]));
    entry_o.old   = $signed(rdata[0]);
    entry_o.fixed = s1_fixed_q;
    entry_o.last  = s1_last_q;
    entry_o.clr   = s1_clr_q || pend_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q   <= interior;
      s1_fixed_q <= fixed;
      s1_last_q  <= last;
      s1_clr_q   <= in_data_i.block_start;
      s1_v_q     <= in_data_i.cell_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      pend_q     <= 1'b0;
      px_q       <= '0;
      py_q       <= '0;
      pz_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        px_q       <= px_d;
        py_q       <= py_d;
        pz_q       <= pz_d;
      end else if (leave) begin
        s1_valid_q <= 1'b0;
      end
      // A block start with no result of its own clears the maximum with the next one.
      if (s1_valid_q && leave) begin
        pend_q <= push_o ? 1'b0 : (pend_q || s1_clr_q);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/j3d_back.sv -----
`default_nettype none
`include "jacobi_3d_seven_point_stencil_defines.svh"
module j3d_back
  import j3d_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire work_t entry_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output cell_out_t  out_data_o
);

  localparam int PrW = SumBits + RecipBits;
  localparam int QW  = PrW - RecipShift;
  localparam int VB  = ValueBits;

  logic pipe_en;

  logic                        p_valid_q, p_fixed_q, p_last_q, p_clr_q;
  logic signed [PrW-1:0]       p_prod_q;
  logic signed [VB-1:0]        p_old_q;

  logic                        n_valid_q, n_last_q, n_clr_q;
  logic signed [VB-1:0]        n_nv_q;
  logic [VB-2:0]               n_diff_q;

  logic                        out_valid_q;
  cell_out_t                   out_q;
  logic [VB-2:0]               max_q;

  logic signed [PrW-1:0]       rnd;
  logic signed [QW-1:0]        q;
  logic signed [VB-1:0]        nv;
  logic signed [VB:0]          d;
  logic [VB:0]                 ad;
  logic [VB-2:0]               diff, mx;

  assign pipe_en     = !out_valid_q || out_ready_i;
  assign pop_o       = !empty_i && pipe_en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    rnd = p_prod_q + (PrW'(1) <<< (RecipShift - 1));
    q   = QW'(rnd >>> RecipShift);
    if (q[QW-1:VB-1] == '0 || q[QW-1:VB-1] == '1) begin
      nv = VB'(q);
    end else begin
      nv = q[QW-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    end
    if (p_fixed_q) begin
      nv = p_old_q;
    end
    d  = {nv[VB-1], nv} - {p_old_q[VB-1], p_old_q};
    ad = d[VB] ? (VB+1)'(-d) : (VB+1)'(d);
    diff = (ad[VB:VB-1] != '0) ? '1 : ad[VB-2:0];
  end

  assign mx = (n_clr_q || n_diff_q > max_q) ? n_diff_q : max_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p_prod_q  <= PrW'(entry_i.sum) * PrW'(Recip7);
      p_old_q   <= entry_i.old;
      p_fixed_q <= entry_i.fixed;
      p_last_q  <= entry_i.last;
      p_clr_q   <= entry_i.clr;
      n_nv_q    <= nv;
      n_diff_q  <= diff;
      n_last_q  <= p_last_q;
      n_clr_q   <= p_clr_q;
      if (n_valid_q) begin
        out_q.new_value  <= n_nv_q;
        out_q.max_change <= mx;
        out_q.last_cell  <= n_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      n_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      max_q       <= '0;
    end else if (pipe_en) begin
      p_valid_q   <= pop_o;
      n_valid_q   <= p_valid_q;
      out_valid_q <= n_valid_q;
      if (n_valid_q) begin
        max_q <= mx;
      end
    end
  end

  `J3D_ASSERT_NEXT(a_max_grows, pipe_en && n_valid_q && !n_clr_q, max_q >= $past(max_q),
                   "running maximum fell without a block start")
  `J3D_ASSERT_NOW(a_max_shown, out_valid_q, out_q.max_change == max_q,
                  "shown maximum differs from the running maximum")
  `J3D_ASSERT_NEXT(a_out_held, out_valid_q && !out_ready_i, out_valid_q && $stable(out_q),
                   "stalled result changed")

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import j3d_pkg::*;

  localparam int PadSide = MaxSideDef + 2;
  localparam int PlaneCells = PadSide * PadSide;
  localparam int StallLimit = 20000;
  localparam logic signed [63:0] RecipSeven = 64'sd38347922;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [SizeBits-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cell_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cell_out_t out_data_o;

  jacobi_3d_seven_point_stencil DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [31:0] planes [2*PlaneCells];
  int unsigned px, py, pz;
  logic [30:0] peak_change;
  int unsigned ext_x = 8, ext_y = 8, ext_z = 8;
  logic [5:0] faces = '0;

  cell_out_t pending_cells[$];
  int errors = 0;
  int idle_in_pct = 0, stall_out_pct = 0;
  int quiet_cycles = 0;

  function automatic int unsigned clip_side(int unsigned s);
    if (s < 1) return 1;
    if (s > MaxSideDef) return MaxSideDef;
    return s;
  endfunction

  function automatic logic signed [63:0] plane_at(int unsigned slot, int unsigned y,
                                                  int unsigned z);
    return 64'(planes[(slot & 1) * PlaneCells + (y % PadSide) * PadSide + (z % PadSide)]);
  endfunction

  function automatic logic signed [63:0] average7(logic signed [63:0] total);
    logic signed [63:0] prod, q;
    prod = total * RecipSeven;
    q = (prod + 64'sd134217728) >>> 28;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  task automatic predict_cell(cell_in_t c);
    int unsigned sx, sy, sz, x, y, z, i;
    logic signed [63:0] v, old, nv, diff;
    logic pinned;
    cell_out_t r;
    sx = clip_side(ext_x); sy = clip_side(ext_y); sz = clip_side(ext_z);
    v = 64'(c.cell_value);
    if (c.block_start) begin
      px = 0; py = 0; pz = 0; peak_change = '0;
    end
    if (px > sx + 1) px = 0;
    if (py > sy + 1) py = 0;
    if (pz > sz + 1) pz = 0;
    x = px; y = py; z = pz;
    if (x >= 2 && y >= 1 && y <= sy && z >= 1 && z <= sz) begin
      i = x - 1;
      old = plane_at(i, y, z);
      pinned = (faces[0] && i == 1) || (faces[1] && i == sx) || (faces[2] && y == 1) ||
               (faces[3] && y == sy) || (faces[4] && z == 1) || (faces[5] && z == sz);
      if (pinned) nv = old;
      else nv = average7(old + v + plane_at(x, y, z) + plane_at(i, y - 1, z) +
                         plane_at(i, y + 1, z) + plane_at(i, y, z - 1) + plane_at(i, y, z + 1));
      diff = (nv >= old) ? nv - old : old - nv;
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      if (diff[30:0] > peak_change) peak_change = diff[30:0];
      r.new_value = nv[31:0];
      r.max_change = peak_change;
      r.last_cell = (i == sx && y == sy && z == sz);
      pending_cells.push_back(r);
    end
    planes[(x & 1) * PlaneCells + (y % PadSide) * PadSide + (z % PadSide)] = v[31:0];
    if (z + 1 <= sz + 1) pz = z + 1;
    else begin
      pz = 0;
      if (y + 1 <= sy + 1) py = y + 1;
      else begin
        py = 0;
        px = (x + 1 <= sx + 1) ? x + 1 : 0;
      end
    end
  endtask

  task automatic send_cell(logic signed [31:0] value, logic first);
    while (idle_in_pct > 0 && $urandom_range(99, 0) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{cell_value: value, block_start: first};
    do @(posedge clk_i); while (!in_ready_o);
    predict_cell('{cell_value: value, block_start: first});
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [SizeBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SIZE_X: ext_x = data;
      CFG_SIZE_Y: ext_y = data;
      CFG_SIZE_Z: ext_z = data;
      default: faces = data[5:0];
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Value generator: modes 0 to 2 give fixed values (maximum, minimum, 0x40000000), any other mode a random value.
  function automatic logic signed [31:0] pick_value(int mode);
    case (mode)
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh40000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(int mode);
    int unsigned n;
    n = (clip_side(ext_x) + 2) * (clip_side(ext_y) + 2) * (clip_side(ext_z) + 2);
    for (int k = 0; k < n; k++)
      send_cell(pick_value(mode == 4 ? $urandom_range(7, 0) : mode), k == 0);
  endtask

  task automatic configure(int sx, int sy, int sz, int fm);
    drain();
    write_reg(CFG_SIZE_X, sx[6:0]);
    write_reg(CFG_SIZE_Y, sy[6:0]);
    write_reg(CFG_SIZE_Z, sz[6:0]);
    write_reg(CFG_FACE_MASK, fm[6:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_extremes();
    configure(1, 1, 1, 0);
    send_block(0);
    send_block(1);
  endtask

  task automatic test_faces();
    configure(2, 1, 2, 6'h3F);
    send_block(4);
    configure(1, 2, 1, 6'h15);
    send_block(4);
    configure(2, 2, 1, 6'h2A);
    send_block(4);
  endtask

  task automatic test_clamped_sizes();
    // Zero means one; out-of-range sizes clamp to the maximum side.
    configure(0, 0, 0, 0);
    send_block(4);
    // Only the first planes of the long block are sent; the next block restarts.
    configure(127, 1, 1, 0);
    for (int k = 0; k < 45; k++) send_cell($urandom(), k == 0);
  endtask

  task automatic test_no_start();
    // Second block follows by wrap alone, with no start flag.
    configure(1, 1, 1, 0);
    send_block(4);
    for (int k = 0; k < 27; k++) send_cell($urandom(), 1'b0);
  endtask

  task automatic test_random(int pin, int pout);
    idle_in_pct = pin;
    stall_out_pct = pout;
    configure($urandom_range(2, 1), $urandom_range(2, 1), $urandom_range(3, 1),
              $urandom_range(63, 0));
    send_block(4);
    if ($urandom_range(3, 0) == 0) begin
      // Broken block: restart midway.
      for (int k = 0; k < 10; k++) send_cell($urandom(), k == 0);
      send_block(4);
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected result new_value=%h", out_data_o.new_value);
        errors++;
      end else begin
        cell_out_t e;
        e = pending_cells.pop_front();
        if (e.new_value !== out_data_o.new_value) begin
          $error("new_value expected %h got %h", e.new_value, out_data_o.new_value);
          errors++;
        end
        if (e.max_change !== out_data_o.max_change) begin
          $error("max_change expected %h got %h", e.max_change, out_data_o.max_change);
          errors++;
        end
        if (e.last_cell !== out_data_o.last_cell) begin
          $error("last_cell expected %b got %b", e.last_cell, out_data_o.last_cell);
          errors++;
        end
      end
    end
    out_ready_i <= !(stall_out_pct > 0 && $urandom_range(99, 0) < stall_out_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    px = 0; py = 0; pz = 0; peak_change = '0;
    foreach (planes[k]) planes[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_faces();
    test_clamped_sizes();
    test_no_start();
    test_random(0, 0);
    test_random(77, 0);
    test_random(0, 77);
    test_random(13, 13);
    test_random(0, 0);
    drain();
    if (errors == 0 && pending_cells.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/j3d_pkg.sv
rtl/j3d_ram.sv
rtl/j3d_queue.sv
rtl/j3d_front.sv
rtl/j3d_back.sv
rtl/jacobi_3d_seven_point_stencil.sv
dv/tb.sv
